@@ hw/rtl/nds_pkg.sv @@
package nds_pkg;

  localparam int INDEX_BITS_DEF = 24;
  localparam int COORD_BITS_DEF = 48;
  localparam int FRAC_BITS_DEF  = 30;

  localparam int QUERY_BITS = 32;
  localparam int SCORE_BITS = 32;
  localparam int CFG_IDX_BITS = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_OBS_X = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_OBS_Y = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_OBS_Z = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_QRY_X = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_QRY_Y = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_QRY_Z = 3'd5;

  // classification of one queued request
  typedef struct packed {
    logic entry;
    logic last;
    logic sat;
  } item_flags_t;

  // status of one emitted result
  typedef struct packed {
    logic overflow;
    logic found;
  } result_flags_t;

endpackage

@@ hw/rtl/nds_front.sv @@
module nds_front import nds_pkg::*; #(
  parameter int INDEX_BITS = INDEX_BITS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_entry,
  input  logic                         in_dir_only,
  input  logic                         in_last,
  input  logic signed [COORD_BITS-1:0] pos_x,
  input  logic signed [COORD_BITS-1:0] pos_y,
  input  logic signed [COORD_BITS-1:0] pos_z,
  input  logic signed [COORD_BITS-1:0] obs_x,
  input  logic signed [COORD_BITS-1:0] obs_y,
  input  logic signed [COORD_BITS-1:0] obs_z,
  input  logic                         q_full,
  output logic                         q_push,
  output logic signed [COORD_BITS:0]   vx,
  output logic signed [COORD_BITS:0]   vy,
  output logic signed [COORD_BITS:0]   vz,
  output logic [INDEX_BITS-1:0]        idx,
  output item_flags_t                  flags
);

  logic [INDEX_BITS-1:0] cnt_r, cnt_nxt;
  logic                  sat_r, sat_nxt;
  logic                  sat_upd;
  logic                  accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;
  assign idx      = cnt_r;

  assign vx = {pos_x[COORD_BITS-1], pos_x} - (in_dir_only ? '0 : {obs_x[COORD_BITS-1], obs_x});
  assign vy = {pos_y[COORD_BITS-1], pos_y} - (in_dir_only ? '0 : {obs_y[COORD_BITS-1], obs_y});
  assign vz = {pos_z[COORD_BITS-1], pos_z} - (in_dir_only ? '0 : {obs_z[COORD_BITS-1], obs_z});

  always_comb begin
    cnt_nxt = cnt_r;
    sat_upd = sat_r;
    if (accept && in_entry) begin
      // saturate at the top index and flag it
      if (cnt_r == '1) sat_upd = 1'b1;
      else cnt_nxt = cnt_r + 1'b1;
    end
    sat_nxt     = sat_upd;
    flags.entry = in_entry;
    flags.last  = in_last;
    flags.sat   = sat_upd;
    if (accept && in_last) begin
      cnt_nxt = '0;
      sat_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sat_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      sat_r <= sat_nxt;
    end
  end

endmodule

@@ hw/rtl/nds_queue.sv @@
module nds_queue import nds_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wp_r, rp_r;
  logic [AW:0]      cnt_r;

  assign full  = (cnt_r == (AW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

@@ hw/rtl/nds_score.sv @@
module nds_score import nds_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [COORD_BITS:0]   vx,
  input  logic signed [COORD_BITS:0]   vy,
  input  logic signed [COORD_BITS:0]   vz,
  input  logic signed [QUERY_BITS-1:0] qx,
  input  logic signed [QUERY_BITS-1:0] qy,
  input  logic signed [QUERY_BITS-1:0] qz,
  output logic                         done,
  output logic signed [SCORE_BITS-1:0] score
);

  localparam int MW = COORD_BITS + 1;
  localparam int NW = (MW > 32) ? MW : 32;

  typedef enum logic [3:0] {
    S_IDLE, S_NORM, S_SQ, S_SQRT, S_DINIT, S_DIV, S_MUL, S_ACC, S_FIN
  } state_t;

  state_t                   state_r, state_nxt;
  logic [NW-1:0]            mag_r [3];
  logic [NW-1:0]            mag_nxt [3];
  logic [2:0]               neg_r, neg_nxt;
  logic [1:0]               k_r, k_nxt;
  logic [4:0]               cnt_r, cnt_nxt;
  logic [63:0]              s_r, s_nxt;
  logic [33:0]              rem_r, rem_nxt;
  logic [31:0]              root_r, root_nxt;
  logic [31:0]              drem_r, drem_nxt;
  logic [FRAC_BITS:0]       db_r, db_nxt;
  logic [FRAC_BITS:0]       quo_r, quo_nxt;
  logic signed [63:0]       prod_r, prod_nxt;
  logic signed [63:0]       acc_r, acc_nxt;
  logic signed [SCORE_BITS-1:0] score_r, score_nxt;
  logic                     done_r, done_nxt;

  logic [NW-1:0]            orv;
  logic [30:0]              m31;
  logic [61:0]              sq;
  logic [35:0]              st, strial;
  logic [32:0]              dt;
  logic signed [FRAC_BITS+1:0]  u_s;
  logic signed [QUERY_BITS-1:0] q_s;
  logic signed [63:0]       sh;

  assign done  = done_r;
  assign score = score_r;

  always_comb begin
    orv    = mag_r[0] | mag_r[1] | mag_r[2];
    m31    = mag_r[k_r][30:0];
    sq     = m31 * m31;
    st     = {rem_r, s_r[63:62]};
    strial = {2'b00, root_r, 2'b01};
    dt     = {drem_r, db_r[FRAC_BITS]};
    u_s    = neg_r[k_r] ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
    case (k_r)
      2'd0:    q_s = qx;
      2'd1:    q_s = qy;
      default: q_s = qz;
    endcase
    sh = acc_r >>> FRAC_BITS;

    state_nxt = state_r;
    for (int i = 0; i < 3; i++) mag_nxt[i] = mag_r[i];
    neg_nxt   = neg_r;
    k_nxt     = k_r;
    cnt_nxt   = cnt_r;
    s_nxt     = s_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    drem_nxt  = drem_r;
    db_nxt    = db_r;
    quo_nxt   = quo_r;
    prod_nxt  = prod_r;
    acc_nxt   = acc_r;
    score_nxt = score_r;
    done_nxt  = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          mag_nxt[0] = NW'(vx[COORD_BITS] ? MW'(-vx) : MW'(vx));
          mag_nxt[1] = NW'(vy[COORD_BITS] ? MW'(-vy) : MW'(vy));
          mag_nxt[2] = NW'(vz[COORD_BITS] ? MW'(-vz) : MW'(vz));
          neg_nxt    = {vz[COORD_BITS], vy[COORD_BITS], vx[COORD_BITS]};
          state_nxt  = S_NORM;
        end
      end
      S_NORM: begin
        // bring the largest magnitude into [2^30, 2^31), one bit a cycle
        if (orv == '0) begin
          score_nxt = '0;
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else if ((orv >> 31) != '0) begin
          for (int i = 0; i < 3; i++) mag_nxt[i] = mag_r[i] >> 1;
        end else if (!orv[30]) begin
          for (int i = 0; i < 3; i++) mag_nxt[i] = mag_r[i] << 1;
        end else begin
          k_nxt     = '0;
          s_nxt     = '0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        s_nxt = s_r + {2'b00, sq};
        if (k_r == 2'd2) begin
          rem_nxt   = '0;
          root_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = S_SQRT;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_SQRT: begin
        // one root bit a cycle
        if (st >= strial) begin
          rem_nxt  = 34'(st - strial);
          root_nxt = {root_r[30:0], 1'b1};
        end else begin
          rem_nxt  = st[33:0];
          root_nxt = {root_r[30:0], 1'b0};
        end
        s_nxt   = s_r << 2;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 5'd31) begin
          k_nxt     = '0;
          state_nxt = S_DINIT;
        end
      end
      S_DINIT: begin
        drem_nxt  = 32'(mag_r[k_r][30:1]);
        db_nxt    = {mag_r[k_r][0], {FRAC_BITS{1'b0}}};
        quo_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        // one quotient bit a cycle
        if (dt >= {1'b0, root_r}) begin
          drem_nxt = 32'(dt - {1'b0, root_r});
          quo_nxt  = {quo_r[FRAC_BITS-1:0], 1'b1};
        end else begin
          drem_nxt = dt[31:0];
          quo_nxt  = {quo_r[FRAC_BITS-1:0], 1'b0};
        end
        db_nxt  = db_r << 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 5'(FRAC_BITS)) state_nxt = S_MUL;
      end
      S_MUL: begin
        prod_nxt  = 64'(u_s) * 64'(q_s);
        state_nxt = S_ACC;
      end
      S_ACC: begin
        acc_nxt = ((k_r == 2'd0) ? 64'sd0 : acc_r) + prod_r;
        if (k_r == 2'd2) begin
          state_nxt = S_FIN;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_DINIT;
        end
      end
      S_FIN: begin
        if (sh > 64'sd2147483647)       score_nxt = 32'sh7fffffff;
        else if (sh < -64'sd2147483648) score_nxt = 32'sh80000000;
        else                            score_nxt = sh[31:0];
        done_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    for (int i = 0; i < 3; i++) mag_r[i] <= mag_nxt[i];
    neg_r   <= neg_nxt;
    k_r     <= k_nxt;
    cnt_r   <= cnt_nxt;
    s_r     <= s_nxt;
    rem_r   <= rem_nxt;
    root_r  <= root_nxt;
    drem_r  <= drem_nxt;
    db_r    <= db_nxt;
    quo_r   <= quo_nxt;
    prod_r  <= prod_nxt;
    acc_r   <= acc_nxt;
    score_r <= score_nxt;
  end

endmodule

@@ hw/rtl/nds_back.sv @@
module nds_back import nds_pkg::*; #(
  parameter int INDEX_BITS = INDEX_BITS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  output logic                         q_pop,
  input  logic signed [COORD_BITS:0]   vx,
  input  logic signed [COORD_BITS:0]   vy,
  input  logic signed [COORD_BITS:0]   vz,
  input  logic [INDEX_BITS-1:0]        idx,
  input  item_flags_t                  flags,
  input  logic signed [QUERY_BITS-1:0] qx,
  input  logic signed [QUERY_BITS-1:0] qy,
  input  logic signed [QUERY_BITS-1:0] qz,
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic [INDEX_BITS-1:0]        res_index,
  output logic signed [SCORE_BITS-1:0] res_score,
  output result_flags_t                res_flags
);

  localparam logic signed [SCORE_BITS-1:0] BEST_INIT = -(32'sd2 <<< FRAC_BITS);

  typedef enum logic [1:0] {B_IDLE, B_WAIT, B_EMIT} state_t;

  state_t                       state_r, state_nxt;
  logic [INDEX_BITS-1:0]        cur_idx_r, cur_idx_nxt;
  item_flags_t                  cur_r, cur_nxt;
  logic signed [SCORE_BITS-1:0] best_r, best_nxt;
  logic [INDEX_BITS-1:0]        bidx_r, bidx_nxt;
  logic                         any_r, any_nxt;
  logic                         ov_r, ov_nxt;
  logic [INDEX_BITS-1:0]        oidx_r, oidx_nxt;
  logic signed [SCORE_BITS-1:0] oscore_r, oscore_nxt;
  result_flags_t                oflags_r, oflags_nxt;
  logic                         sc_start, sc_done;
  logic signed [SCORE_BITS-1:0] sc_score;

  nds_score #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_score (
    .clk, .rst_n, .start(sc_start), .vx, .vy, .vz, .qx, .qy, .qz,
    .done(sc_done), .score(sc_score)
  );

  assign res_valid = ov_r;
  assign res_index = oidx_r;
  assign res_score = oscore_r;
  assign res_flags = oflags_r;

  always_comb begin
    state_nxt   = state_r;
    cur_idx_nxt = cur_idx_r;
    cur_nxt     = cur_r;
    best_nxt    = best_r;
    bidx_nxt    = bidx_r;
    any_nxt     = any_r;
    ov_nxt      = ov_r && !res_ready;
    oidx_nxt    = oidx_r;
    oscore_nxt  = oscore_r;
    oflags_nxt  = oflags_r;
    q_pop       = 1'b0;
    sc_start    = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop       = 1'b1;
          cur_idx_nxt = idx;
          cur_nxt     = flags;
          if (flags.entry) begin
            sc_start  = 1'b1;
            state_nxt = B_WAIT;
          end else if (flags.last) begin
            state_nxt = B_EMIT;
          end
        end
      end
      B_WAIT: begin
        if (sc_done) begin
          // strict compare: ties keep the earlier entry
          if (!any_r || (sc_score > best_r)) begin
            best_nxt = sc_score;
            bidx_nxt = cur_idx_r;
          end
          any_nxt   = 1'b1;
          state_nxt = cur_r.last ? B_EMIT : B_IDLE;
        end
      end
      B_EMIT: begin
        if (!ov_r || res_ready) begin
          ov_nxt              = 1'b1;
          oflags_nxt.found    = any_r;
          oflags_nxt.overflow = cur_r.sat;
          oidx_nxt            = any_r ? bidx_r : '0;
          oscore_nxt          = any_r ? best_r : '0;
          best_nxt            = BEST_INIT;
          bidx_nxt            = '0;
          any_nxt             = 1'b0;
          state_nxt           = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      best_r  <= BEST_INIT;
      bidx_r  <= '0;
      any_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      best_r  <= best_nxt;
      bidx_r  <= bidx_nxt;
      any_r   <= any_nxt;
      ov_r    <= ov_nxt;
    end
    cur_idx_r <= cur_idx_nxt;
    cur_r     <= cur_nxt;
    oidx_r    <= oidx_nxt;
    oscore_r  <= oscore_nxt;
    oflags_r  <= oflags_nxt;
  end

endmodule

@@ hw/rtl/nearest_direction_search.sv @@
// Scoring: with the back idle, a result leaves once the last entry of the pass is scored; the
//   scoring unit normalises with one-bit shifts, then takes a square root and three divisions,
//   one bit a cycle.
// Throughput: one entry per scoring pass; a request without an entry is taken without scoring.
// Reset: rst_n synchronous, active low; observer cleared, query set to (1.0, 0, 0),
//   pass state cleared, queue emptied.
module nearest_direction_search import nds_pkg::*; #(
  parameter int INDEX_BITS = INDEX_BITS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // pos_x, pos_y, pos_z from bit 0 up, zero padded to whole bytes
  input  logic [((3*COORD_BITS+7)/8)*8-1:0] in_tdata,
  // entry_valid, direction_only from bit 0 up
  input  logic [1:0] in_tuser,
  input  logic in_tlast,
  output logic out_tvalid,
  input  logic out_tready,
  // best_index, best_score from bit 0 up, zero padded to whole bytes
  output logic [((INDEX_BITS+SCORE_BITS+7)/8)*8-1:0] out_tdata,
  // found, index_overflow from bit 0 up
  output logic [1:0] out_tuser,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [((COORD_BITS > QUERY_BITS) ? COORD_BITS : QUERY_BITS)-1:0] cfg_data
);

  localparam int VW = COORD_BITS + 1;
  localparam int QW = 3*VW + INDEX_BITS + $bits(item_flags_t);
  localparam int OW = ((INDEX_BITS+SCORE_BITS+7)/8)*8;

  // configuration registers: the user writes them only while idle; the block does not enforce it
  logic signed [COORD_BITS-1:0] obs_x_r, obs_y_r, obs_z_r;
  logic signed [QUERY_BITS-1:0] qry_x_r, qry_y_r, qry_z_r;

  logic                  q_push, q_pop, q_full, q_empty;
  logic [QW-1:0]         q_wdata, q_rdata;
  logic signed [COORD_BITS:0] f_vx, f_vy, f_vz, b_vx, b_vy, b_vz;
  logic [INDEX_BITS-1:0] f_idx, b_idx, r_idx;
  item_flags_t           f_flags, b_flags;
  logic signed [SCORE_BITS-1:0] r_score;
  result_flags_t         r_flags;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obs_x_r <= '0;
      obs_y_r <= '0;
      obs_z_r <= '0;
      qry_x_r <= QUERY_BITS'(64'sd1 <<< FRAC_BITS);
      qry_y_r <= '0;
      qry_z_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_OBS_X: obs_x_r <= cfg_data[COORD_BITS-1:0];
        REG_OBS_Y: obs_y_r <= cfg_data[COORD_BITS-1:0];
        REG_OBS_Z: obs_z_r <= cfg_data[COORD_BITS-1:0];
        REG_QRY_X: qry_x_r <= cfg_data[QUERY_BITS-1:0];
        REG_QRY_Y: qry_y_r <= cfg_data[QUERY_BITS-1:0];
        REG_QRY_Z: qry_z_r <= cfg_data[QUERY_BITS-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // front: accept, subtract the observer unless direction only, number the entries
  nds_front #(.INDEX_BITS(INDEX_BITS), .COORD_BITS(COORD_BITS)) u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .in_entry(in_tuser[0]), .in_dir_only(in_tuser[1]), .in_last(in_tlast),
    .pos_x(in_tdata[COORD_BITS-1:0]),
    .pos_y(in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .pos_z(in_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .obs_x(obs_x_r), .obs_y(obs_y_r), .obs_z(obs_z_r),
    .q_full, .q_push,
    .vx(f_vx), .vy(f_vy), .vz(f_vz), .idx(f_idx), .flags(f_flags)
  );

  assign q_wdata = {f_flags, f_idx, f_vz, f_vy, f_vx};
  assign {b_flags, b_idx, b_vz, b_vy, b_vx} = q_rdata;

  // short queue: lets the front keep taking requests while an entry is scored
  nds_queue #(.WIDTH(QW), .DEPTH(2)) u_queue (
    .clk, .rst_n, .push(q_push), .wdata(q_wdata), .pop(q_pop),
    .rdata(q_rdata), .full(q_full), .empty(q_empty)
  );

  // back: score, keep the best, hold the result until taken
  nds_back #(.INDEX_BITS(INDEX_BITS), .COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n, .q_empty, .q_pop,
    .vx(b_vx), .vy(b_vy), .vz(b_vz), .idx(b_idx), .flags(b_flags),
    .qx(qry_x_r), .qy(qry_y_r), .qz(qry_z_r),
    .res_valid(out_tvalid), .res_ready(out_tready),
    .res_index(r_idx), .res_score(r_score), .res_flags(r_flags)
  );

  assign out_tdata = OW'({r_score, r_idx});
  assign out_tuser = {r_flags.overflow, r_flags.found};

  // a pop never hits an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("pop from empty queue");

  // an empty pass reports zero index and score
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !r_flags.found) |-> (r_idx == '0 && r_score == '0))
    else $error("empty pass with nonzero fields");

  // the front does not push while the queue stays full
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (q_full && !q_pop) |=> !q_push || q_pop || !q_full)
    else $error("push into full queue");

endmodule
